### src/max_xor_pair_trie_assert.svh
// Assertion macros for the trie block
`ifndef MAX_XOR_PAIR_TRIE_ASSERT_SVH
`define MAX_XOR_PAIR_TRIE_ASSERT_SVH

// same-cycle implication
`define MXT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("max_xor_pair_trie: assertion failed");

// next-cycle implication
`define MXT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("max_xor_pair_trie: assertion failed");

`endif

### src/mxt_pkg.sv
package mxt_pkg;

  localparam int KEY_BITS  = 60;
  localparam int NODE_POOL = 65536;
  localparam int IDX_W     = $clog2(NODE_POOL);
  localparam int CNT_W     = $clog2(NODE_POOL + 1);
  localparam int LVL_W     = $clog2(KEY_BITS);
  localparam int NEED_W    = $clog2(KEY_BITS + 1);

  typedef struct packed {
    logic [IDX_W-1:0] c1;
    logic [IDX_W-1:0] c0;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QWALK,
    ST_NINIT,
    ST_NWALK,
    ST_CHECK,
    ST_LINK,
    ST_ALLOC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic q_step;
    logic n_init;
    logic n_step;
    logic link;
    logic alloc;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic q_stop;
    logic n_stop;
    logic full;
    logic need_zero;
    logic alloc_last;
  } dp_sts_t;

endpackage

### src/mxt_ctrl.sv
module mxt_ctrl import mxt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_QWALK;
        end
      end
      ST_QWALK: begin
        cmd.q_step = 1'b1;
        if (sts.q_stop) state_nxt = ST_NINIT;
      end
      ST_NINIT: begin
        cmd.n_init = 1'b1;
        state_nxt  = ST_NWALK;
      end
      ST_NWALK: begin
        cmd.n_step = 1'b1;
        if (sts.n_stop) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.full || sts.need_zero) state_nxt = ST_DONE;
        else state_nxt = ST_LINK;
      end
      ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = ST_ALLOC;
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        if (sts.alloc_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### src/mxt_dp.sv
module mxt_dp import mxt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [KEY_BITS-1:0] in_key_value,
  output logic [KEY_BITS-1:0] out_best_xor,
  output logic [KEY_BITS-1:0] out_running_max_xor,
  output logic                out_pool_full
);

  localparam logic [LVL_W-1:0] TOP_POS = LVL_W'(KEY_BITS - 1);

  node_t mem [NODE_POOL];

  logic [KEY_BITS-1:0] key_r, acc_r, best_r;
  logic [KEY_BITS-1:0] best_out_r, found_out_r;
  logic                full_out_r;
  logic [LVL_W-1:0]    pos_r;
  logic [IDX_W-1:0]    cur_r, alloc_r, br_idx_r;
  logic                at_root_r, br_root_r;
  node_t               root_r, rd_data_r, br_data_r;
  logic [CNT_W-1:0]    nodes_used_r;
  logic [NEED_W-1:0]   need_r;

  node_t               node_c, link_node, alloc_node, wd;
  logic                key_bit, q_pref, n_miss, we, full;
  logic [IDX_W-1:0]    child_same, child_opp, q_next, ra, wa;
  logic [LVL_W-1:0]    posm1;
  logic [CNT_W:0]      sum;
  logic [KEY_BITS-1:0] best_nxt;

  always_comb begin
    node_c     = at_root_r ? root_r : rd_data_r;
    key_bit    = key_r[pos_r];
    child_same = key_bit ? node_c.c1 : node_c.c0;
    child_opp  = key_bit ? node_c.c0 : node_c.c1;
    q_pref     = (child_opp != '0);
    q_next     = q_pref ? child_opp : child_same;
    n_miss     = (child_same == '0);
    ra         = cmd.q_step ? q_next : child_same;
    posm1      = pos_r - 1'b1;

    // branch node gains a pointer to the first new node
    link_node = br_data_r;
    if (key_bit) link_node.c1 = nodes_used_r[IDX_W-1:0];
    else link_node.c0 = nodes_used_r[IDX_W-1:0];

    // new node points at the next one, leaf has no children
    alloc_node = '0;
    if (pos_r != '0) begin
      if (key_r[posm1]) alloc_node.c1 = alloc_r + 1'b1;
      else alloc_node.c0 = alloc_r + 1'b1;
    end

    we = (cmd.link && !br_root_r) || cmd.alloc;
    wa = cmd.link ? br_idx_r : alloc_r;
    wd = cmd.link ? link_node : alloc_node;

    sum      = {1'b0, nodes_used_r} + (CNT_W + 1)'(need_r);
    full     = (sum > (CNT_W + 1)'(NODE_POOL));
    best_nxt = (!full && (acc_r > best_r)) ? acc_r : best_r;

    sts.q_stop     = ((child_opp == '0) && (child_same == '0)) || (pos_r == '0);
    sts.n_stop     = n_miss || (pos_r == '0);
    sts.full       = full;
    sts.need_zero  = (need_r == '0);
    sts.alloc_last = (pos_r == '0);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      nodes_used_r <= CNT_W'(1);
      best_r       <= '0;
    end else begin
      if (cmd.link && br_root_r) root_r <= link_node;
      if (cmd.commit && !full) begin
        nodes_used_r <= sum[CNT_W-1:0];
        best_r       <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_key_value;
      acc_r     <= '0;
      pos_r     <= TOP_POS;
      cur_r     <= '0;
      at_root_r <= 1'b1;
    end
    if (cmd.q_step) begin
      if (q_pref) acc_r[pos_r] <= 1'b1;
      cur_r     <= q_next;
      at_root_r <= 1'b0;
      pos_r     <= posm1;
    end
    if (cmd.n_init) begin
      pos_r     <= TOP_POS;
      cur_r     <= '0;
      at_root_r <= 1'b1;
      need_r    <= '0;
    end
    if (cmd.n_step) begin
      if (n_miss) begin
        need_r    <= NEED_W'(pos_r) + NEED_W'(1);
        br_idx_r  <= cur_r;
        br_root_r <= at_root_r;
        br_data_r <= node_c;
      end else begin
        cur_r     <= child_same;
        at_root_r <= 1'b0;
        pos_r     <= posm1;
      end
    end
    if (cmd.link) alloc_r <= nodes_used_r[IDX_W-1:0];
    if (cmd.alloc) begin
      alloc_r <= alloc_r + 1'b1;
      pos_r   <= posm1;
    end
    if (cmd.commit) begin
      found_out_r <= acc_r;
      best_out_r  <= best_nxt;
      full_out_r  <= full;
    end
  end

  assign out_best_xor        = found_out_r;
  assign out_running_max_xor = best_out_r;
  assign out_pool_full       = full_out_r;

endmodule

### src/max_xor_pair_trie.sv
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_stall    | in_key_value
// out      | out_valid / out_stall  | out_best_xor, out_running_max_xor,
//          |                        | out_pool_full
//
// Q is the levels of the opposite-bit walk, N the levels of the own-path walk,
// need the nodes created when new nodes are made (up to 60); each is one
// access to the node memory.
// Reset: node count to one and root children cleared; no clearing pass.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds the block in its final state.
`include "max_xor_pair_trie_assert.svh"

module max_xor_pair_trie import mxt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_BITS-1:0] in_key_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_BITS-1:0] out_best_xor,
  output logic [KEY_BITS-1:0] out_running_max_xor,
  output logic                out_pool_full
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mxt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mxt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_key_value        (in_key_value),
    .out_best_xor        (out_best_xor),
    .out_running_max_xor (out_running_max_xor),
    .out_pool_full       (out_pool_full)
  );

  `MXT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `MXT_ASSERT_NXT(a_commit_shows_word, clk, rst_n, cmd.commit, out_valid)
  `MXT_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
  `MXT_ASSERT_IMP(a_no_write_when_full, clk, rst_n, cmd.link || cmd.alloc, !sts.full)

endmodule
